// ----- sv/ces_pkg.sv -----
// Shared types and constants for the column equalization scale block.
package ces_pkg;
	localparam int unsigned MaxColumnsDefault = 1024;
	localparam int unsigned ColW = 10;
	localparam int unsigned MagW = 16;
	localparam int unsigned ScaleW = 24;
	localparam logic [ScaleW-1:0] ScaleOne = 24'd65536;

	typedef enum logic [1:0] {
		FUNC_WEIGHT = 2'd0,
		FUNC_ACT    = 2'd1,
		FUNC_READ   = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	// request and answer between top level and the divide/root unit
	typedef struct packed {
		logic            start;
		logic [MagW-1:0] wmax;
		logic [MagW-1:0] xmax;
	} ces_calc_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [ScaleW-1:0] root;
	} ces_calc_rsp_t;
endpackage

// ----- sv/ces_ram.sv -----
// Generic single-port RAM with registered read.
module ces_ram #(
	parameter int unsigned Width = 16,
	parameter int unsigned Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- sv/ces_calc.sv -----
// Sequential restoring divide then bit-pair square root for the scale.
module ces_calc (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ces_pkg::ces_calc_req_t req,
	output ces_pkg::ces_calc_rsp_t rsp
);
	import ces_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SQRT} st_t;

	st_t         state_q;
	logic [5:0]  cnt_q;
	logic [47:0] quo_q;     // dividend shifts out, quotient shifts in
	logic [16:0] rem_q;
	logic [MagW-1:0] div_q;
	logic [47:0] val_q;     // radicand remaining
	logic [23:0] root_q;
	logic [25:0] srem_q;
	logic        done_q;

	logic [16:0] rem_sh;
	logic [25:0] srem_sh;
	logic [25:0] trial;

	assign rem_sh  = {rem_q[15:0], quo_q[47]};
	assign srem_sh = {srem_q[23:0], val_q[47:46]};
	assign trial   = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			quo_q   <= '0;
			rem_q   <= '0;
			div_q   <= '0;
			val_q   <= '0;
			root_q  <= '0;
			srem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						quo_q   <= {req.wmax, 32'd0};
						div_q   <= req.xmax;
						rem_q   <= '0;
						cnt_q   <= 6'd47;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (rem_sh >= {1'b0, div_q}) begin
						rem_q <= rem_sh - {1'b0, div_q};
						quo_q <= {quo_q[46:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[46:0], 1'b0};
					end
					if (cnt_q == '0) begin
						// load radicand on the last divide step
						val_q   <= {quo_q[46:0], (rem_sh >= {1'b0, div_q})};
						cnt_q   <= 6'd23;
						root_q  <= '0;
						srem_q  <= '0;
						state_q <= ST_SQRT;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_SQRT: begin
					if (srem_sh >= trial) begin
						srem_q <= srem_sh - trial;
						root_q <= {root_q[22:0], 1'b1};
					end else begin
						srem_q <= srem_sh;
						root_q <= {root_q[22:0], 1'b0};
					end
					val_q <= {val_q[45:0], 2'b00};
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.busy = (state_q != ST_IDLE);
	assign rsp.done = done_q;
	assign rsp.root = root_q;
endmodule

// ----- sv/column_equalization_scale.sv -----
// Top level: per-column max stores and scale read-out.
// Usage:
//  Input channel (in_valid/in_ready) carries func, column, sample. Weight
//  and activation requests update the running magnitude maximum of their
//  column; a read request returns one result on the output channel
//  (out_valid/out_ready): scale = floor(sqrt(wmax*2^32/xmax)) in Q8.16,
//  the column, and defaulted when either maximum was zero or the column
//  is out of range (scale 1.0). The read clears both maxima of that column.
// Flow: a request is taken from idle, then its column is read and modified/written back
//  before the next is taken. A read with both maxima nonzero holds the input
//  until the 48-step divide and 24-step root of the shared sequential unit end.
// Output: out_valid is set from the modify step when defaulted, otherwise
//  after the read, the 48 divide steps, the 24 root steps and capture.
// Reset: a clearing pass writes zero to every entry of both memories in turn,
//  with in_ready low. Output valid is cleared.
// Stall: a result held in the output register blocks only the next read;
//  sample requests keep flowing while the receiver stalls.
module column_equalization_scale #(
	parameter int unsigned MAX_COLUMNS = ces_pkg::MaxColumnsDefault
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 func,
	input  logic [ces_pkg::ColW-1:0]   column,
	input  logic signed [15:0]         sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ces_pkg::ScaleW-1:0] scale,
	output logic [ces_pkg::ColW-1:0]   scale_column,
	output logic                       defaulted
);
	import ces_pkg::*;

	localparam int unsigned AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

	typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_MOD, ST_CALC} st_t;

	st_t             state_q;
	logic [AW:0]     clr_q;
	logic [1:0]      func_q;
	logic [ColW-1:0] col_q;
	logic [MagW-1:0] mag_q;
	logic            hit_q;
	logic            busy_out_q;

	logic [MagW-1:0] w_rd, x_rd, wdata;
	logic            w_we, x_we;
	logic [AW-1:0]   addr;
	logic [16:0]     mag_wide;
	logic            accept, col_ok;
	ces_calc_req_t   creq;
	ces_calc_rsp_t   crsp;

	// 17-bit negate keeps -32768 as 32768
	assign mag_wide = sample[15] ? (17'h10000 - {1'b0, sample}) : {1'b0, sample};
	assign col_ok   = ({22'd0, column} < 32'(MAX_COLUMNS));
	// a read must wait for the output register to drain
	assign in_ready = (state_q == ST_IDLE) &&
		!(func_t'(func) == FUNC_READ && busy_out_q);
	assign accept   = in_valid && in_ready;

	always_comb begin
		addr  = (state_q == ST_CLEAR) ? clr_q[AW-1:0] :
			(state_q == ST_IDLE) ? column[AW-1:0] : col_q[AW-1:0];
		w_we  = 1'b0;
		x_we  = 1'b0;
		wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				w_we = 1'b1;
				x_we = 1'b1;
			end
			ST_MOD: begin
				if (hit_q) begin
					case (func_t'(func_q))
						FUNC_WEIGHT: begin
							w_we  = (mag_q > w_rd);
							wdata = mag_q;
						end
						FUNC_ACT: begin
							x_we  = (mag_q > x_rd);
							wdata = mag_q;
						end
						FUNC_READ: begin
							w_we = 1'b1;
							x_we = 1'b1;
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	ces_ram #(.Width(MagW), .Depth(MAX_COLUMNS)) u_wram (
		.clk(clk), .we(w_we), .addr(addr), .wdata(wdata), .rdata(w_rd));
	ces_ram #(.Width(MagW), .Depth(MAX_COLUMNS)) u_xram (
		.clk(clk), .we(x_we), .addr(addr), .wdata(wdata), .rdata(x_rd));

	assign creq.start = (state_q == ST_MOD) && (func_t'(func_q) == FUNC_READ) &&
		hit_q && (w_rd != '0) && (x_rd != '0);
	assign creq.wmax  = w_rd;
	assign creq.xmax  = x_rd;

	ces_calc u_calc (.clk(clk), .arst_n(arst_n), .req(creq), .rsp(crsp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			func_q     <= '0;
			col_q      <= '0;
			mag_q      <= '0;
			hit_q      <= 1'b0;
			busy_out_q <= 1'b0;
			scale        <= '0;
			scale_column <= '0;
			defaulted    <= 1'b0;
		end else begin
			if (busy_out_q && out_ready) begin
				busy_out_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(MAX_COLUMNS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						func_q  <= func;
						col_q   <= column;
						mag_q   <= mag_wide[15:0] | {mag_wide[16], 15'd0};
						hit_q   <= col_ok;
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					state_q <= ST_IDLE;
					if (func_t'(func_q) == FUNC_READ) begin
						if (creq.start) begin
							state_q <= ST_CALC;
						end else begin
							scale        <= ScaleOne;
							scale_column <= col_q;
							defaulted    <= 1'b1;
							busy_out_q   <= 1'b1;
						end
					end
				end
				ST_CALC: begin
					if (crsp.done) begin
						scale        <= crsp.root;
						scale_column <= col_q;
						defaulted    <= 1'b0;
						busy_out_q   <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = busy_out_q;

	a_no_in_while_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready)
		else $error("input accepted during clearing pass");
	a_calc_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		creq.start |-> !crsp.busy)
		else $error("calc started while busy");
	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		crsp.done |-> (state_q == ST_CALC))
		else $error("calc result outside calc state");
	a_default_one: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && defaulted) |-> (scale == ScaleOne))
		else $error("defaulted result not one");
endmodule

// ----- sim/tb_top.sv -----
// Testbench for column_equalization_scale: random and directed requests, scored against a local model.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ces_pkg::*;

	// Expected result of one read request.
	typedef struct {
		logic [ScaleW-1:0] scale;
		logic [ColW-1:0]   column;
		logic              defaulted;
	} scale_result_t;

	// Scoreboard: mirrors both per-column max stores and queues expected scales.
	class scale_board;
		logic [MagW-1:0] wmax_store [MaxColumnsDefault];
		logic [MagW-1:0] xmax_store [MaxColumnsDefault];
		scale_result_t   pending [$];
		int              errors;

		function new();
			foreach (wmax_store[i]) begin
				wmax_store[i] = '0;
				xmax_store[i] = '0;
			end
			errors = 0;
		endfunction

		static function logic [63:0] root_floor(logic [63:0] v);
			logic [63:0] root;
			logic [63:0] bitv;
			root = 0;
			bitv = 64'd1 << 62;
			while (bitv > v)
				bitv >>= 2;
			while (bitv != 0) begin
				if (v >= root + bitv) begin
					v = v - (root + bitv);
					root = (root >> 1) + bitv;
				end else begin
					root >>= 1;
				end
				bitv >>= 2;
			end
			return root;
		endfunction

		function void note_request(logic [1:0] f, logic [ColW-1:0] col, logic [15:0] smp);
			logic [MagW-1:0] mag;
			logic [63:0]     w;
			logic [63:0]     x;
			scale_result_t   r;
			mag = smp[15] ? (17'h10000 - {1'b0, smp}) : smp; // -32768 maps to 32768
			case (f)
				FUNC_WEIGHT: if (mag > wmax_store[col]) wmax_store[col] = mag;
				FUNC_ACT:    if (mag > xmax_store[col]) xmax_store[col] = mag;
				FUNC_READ: begin
					w = wmax_store[col];
					x = xmax_store[col];
					wmax_store[col] = '0;
					xmax_store[col] = '0;
					r.column = col;
					r.defaulted = (w == 0) || (x == 0);
					r.scale = r.defaulted ? ScaleOne : root_floor((w << 32) / x);
					pending.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [ScaleW-1:0] s, logic [ColW-1:0] c, logic d);
			scale_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result: scale %0d column %0d", s, c);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (s !== e.scale) begin
				$error("scale: expected %0d, got %0d", e.scale, s);
				errors++;
			end
			if (c !== e.column) begin
				$error("scale_column: expected %0d, got %0d", e.column, c);
				errors++;
			end
			if (d !== e.defaulted) begin
				$error("defaulted: expected %0d, got %0d", e.defaulted, d);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        func;
	logic [ColW-1:0]   column;
	logic signed [15:0] sample;
	logic              out_valid;
	logic              out_ready;
	logic [ScaleW-1:0] scale;
	logic [ColW-1:0]   scale_column;
	logic              defaulted;

	scale_board board;
	bit         long_hold;   // receiver asked to stall for a long stretch
	bit         stim_done;

	column_equalization_scale uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .column(column), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.scale(scale), .scale_column(scale_column), .defaulted(defaulted)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Score both channels at the edge, from values settled before it.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			board.note_request(func, column, sample);
		if (arst_n && out_valid && out_ready)
			board.check_result(scale, scale_column, defaulted);
	end

	// Receiver: random stall pattern, with quiet stretches and one long hold-off.
	initial begin : receiver
		int mode;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				// long hold-off, counted here; ends on its own
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				long_hold = 1'b0;
			end
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(5, 60)) begin
				@(posedge clk);
				if (long_hold)
					out_ready <= 1'b0;
				else if (mode == 0)
					out_ready <= 1'b1;
				else if (mode == 1)
					out_ready <= ($urandom_range(0, 3) != 0);
				else if (mode == 2)
					out_ready <= ($urandom_range(0, 3) == 0);
				else
					out_ready <= ~out_ready;
			end
		end
	end

	// Offer one request and hold it until the block takes it.
	task automatic send_request(logic [1:0] f, logic [ColW-1:0] col, logic [15:0] smp);
		in_valid <= 1'b1;
		func     <= f;
		column   <= col;
		sample   <= smp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic idle_cycles(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Wait for the scoreboard to drain.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	// Small column set keeps reads hitting columns that have samples.
	function automatic logic [ColW-1:0] pick_column();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, MaxColumnsDefault - 1);
		return $urandom_range(0, 15);
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return $urandom_range(0, 3);
			3: return -$urandom_range(1, 3);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [1:0] pick_func();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return FUNC_WEIGHT;
		if (r < 85) return FUNC_ACT;
		if (r < 97) return FUNC_READ;
		return FUNC_NONE;
	endfunction

	initial begin : stimulus
		int burst;
		board     = new();
		long_hold = 1'b0;
		stim_done = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		func      = FUNC_NONE;
		column    = '0;
		sample    = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, defaulted reads, most negative sample, unused code.
		send_request(FUNC_READ, 10'd0, 16'h0);              // both maxima zero
		send_request(FUNC_WEIGHT, 10'd1, 16'h8000);         // magnitude 32768
		send_request(FUNC_ACT, 10'd1, 16'h0001);
		send_request(FUNC_READ, 10'd1, 16'hffff);           // largest ratio
		send_request(FUNC_READ, 10'd1, 16'h0);              // cleared by read
		send_request(FUNC_WEIGHT, 10'd1023, 16'h0001);
		send_request(FUNC_ACT, 10'd1023, 16'h8000);         // smallest ratio
		send_request(FUNC_READ, 10'd1023, 16'h0);
		send_request(FUNC_WEIGHT, 10'd2, 16'h7fff);         // weight only
		send_request(FUNC_READ, 10'd2, 16'h0);
		send_request(FUNC_ACT, 10'd3, 16'hffff);            // activation only
		send_request(FUNC_READ, 10'd3, 16'h0);
		send_request(FUNC_NONE, 10'd4, 16'h1234);           // ignored
		send_request(FUNC_WEIGHT, 10'd5, 16'h0005);
		send_request(FUNC_WEIGHT, 10'd5, 16'hfff0);         // larger negative wins
		send_request(FUNC_WEIGHT, 10'd5, 16'h0003);
		send_request(FUNC_ACT, 10'd5, 16'h5555);
		send_request(FUNC_ACT, 10'd5, 16'haaaa);
		send_request(FUNC_READ, 10'd5, 16'h0);
		send_request(FUNC_READ, 10'd682, 16'h0);
		send_request(FUNC_READ, 10'd341, 16'h0);
		wait_drained();

		// Long receiver hold-off while requests keep coming.
		long_hold = 1'b1;
		for (int i = 0; i < 40; i++)
			send_request((i % 4 == 3) ? FUNC_READ : pick_func(), pick_column(), pick_sample());
		wait_drained();

		// Random bursts with gaps.
		for (int n = 0; n < 850; ) begin
			burst = $urandom_range(1, 30);
			for (int i = 0; i < burst; i++, n++)
				send_request(pick_func(), pick_column(), pick_sample());
			if ($urandom_range(0, 9) == 0)
				wait_drained();
			else if ($urandom_range(0, 2) == 0)
				idle_cycles($urandom_range(1, 12));
		end

		// Sweep out every small column so the stores get read back.
		for (int c = 0; c < 16; c++)
			send_request(FUNC_READ, c, $urandom);
		wait_drained();
		repeat (100) @(posedge clk);
		if (board.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Clearing pass plus ~1000 requests, reads holding the input through divide and root, with stalls.
	initial begin : watchdog
		#2000000;
		$display("simulation failed");
		$finish;
	end
endmodule
